// ----- rtl/i2cmis_pkg.sv -----
// Shared types, constants and status bit positions for the I2C master sequencer.
package i2cmis_pkg;

    localparam int LEN_BITS_DEF = 16;
    localparam int LENGTH_W     = 16;
    localparam int STATUS_W     = 16;
    localparam int S_TDATA_W    = 64;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 40;

    localparam int SB_BIT      = 0;
    localparam int ADDR_BIT    = 1;
    localparam int BTF_BIT     = 2;
    localparam int STOPF_BIT   = 4;
    localparam int RXNE_BIT    = 6;
    localparam int TXE_BIT     = 7;
    localparam int BERR_BIT    = 8;
    localparam int ARLO_BIT    = 9;
    localparam int AF_BIT      = 10;
    localparam int OVR_BIT     = 11;
    localparam int TIMEOUT_BIT = 14;

    typedef enum logic [1:0] {
        CMD_START_TX = 2'd0,
        CMD_START_RX = 2'd1,
        CMD_EVENT    = 2'd2,
        CMD_ERROR    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_BUSY_TX = 2'd1,
        ST_BUSY_RX = 2'd2
    } xfer_state_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [LENGTH_W-1:0]   length;
        logic [6:0]            slave_addr;
        logic                  repeat_start;
        logic [STATUS_W-1:0]   status;
        logic                  master_mode;
        logic [7:0]            tx_byte;
        logic [7:0]            rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] prior_state;
        logic       start_gen;
        logic       stop_gen;
        logic       dr_write;
        logic [7:0] dr_value;
        logic       tx_advance;
        logic       rx_store;
        logic [7:0] rx_value;
        logic       addr_clear;
        logic       ack_bit;
        logic [2:0] event_mask;
        logic [4:0] error_mask;
    } result_t;

endpackage

// ----- rtl/i2c_master_interrupt_sequencer.sv -----
// Top level of the interrupt-driven I2C master transfer sequencer.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata (64), s_tuser (2)
//  m_        out        m_tvalid / m_tready  m_tdata (40)
//  cfg_      in         cfg_valid/cfg_ready  cfg_data (1), ack_enable
//
// One result per input transfer: input register, decode, result register.
// One item per cycle sustained while m_tready does not stall; the state update
// is a single pass of flag decode and counter decrement.
// Reset clears the transfer state, interrupt enables and both valid registers.
// A stalled m_tready holds the result; s_tready drops only when both registers
// are full.
module i2c_master_interrupt_sequencer #(
    parameter int LEN_BITS = i2cmis_pkg::LEN_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // length[15:0], slave_addr[22:16], repeat_start[23], status[39:24],
    // master_mode[40], tx_byte[48:41], rx_byte[56:49], zero pad
    input  logic [i2cmis_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd[1:0]
    input  logic [i2cmis_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // prior_state[1:0], start_gen[2], stop_gen[3], dr_write[4], dr_value[12:5],
    // tx_advance[13], rx_store[14], rx_value[22:15], addr_clear[23],
    // ack_bit[24], event_mask[27:25], error_mask[32:28], zero pad
    output logic [i2cmis_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_data
);

    logic                adv;
    logic                out_ready;
    i2cmis_pkg::item_t   item;
    i2cmis_pkg::result_t res;

    i2cmis_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_ready (out_ready),
        .adv       (adv),
        .item      (item)
    );

    i2cmis_engine #(
        .LEN_BITS (LEN_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    i2cmis_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- rtl/i2cmis_in_stage.sv -----
// Input register: captures one stream transfer and unpacks it into an item.
module i2cmis_in_stage (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [i2cmis_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [i2cmis_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                  out_ready,
    output logic                                  adv,
    output i2cmis_pkg::item_t                     item
);

    logic              in_valid_reg;
    logic              in_valid_next;
    i2cmis_pkg::item_t item_reg;

    assign adv      = in_valid_reg && out_ready;
    assign s_tready = !in_valid_reg || out_ready;
    assign item     = item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd          <= i2cmis_pkg::cmd_t'(s_tuser);
            item_reg.length       <= s_tdata[15:0];
            item_reg.slave_addr   <= s_tdata[22:16];
            item_reg.repeat_start <= s_tdata[23];
            item_reg.status       <= s_tdata[39:24];
            item_reg.master_mode  <= s_tdata[40];
            item_reg.tx_byte      <= s_tdata[48:41];
            item_reg.rx_byte      <= s_tdata[56:49];
        end
    end

endmodule

// ----- rtl/i2cmis_engine.sv -----
// Transfer state, flag decode, results: one item per cycle while adv is set.
module i2cmis_engine #(
    parameter int LEN_BITS = i2cmis_pkg::LEN_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  i2cmis_pkg::item_t     item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    output i2cmis_pkg::result_t   res
);

    i2cmis_pkg::xfer_state_t xfer_state_reg, xfer_state_next;
    logic [LEN_BITS-1:0]     tx_rem_reg, tx_rem_next;
    logic [LEN_BITS-1:0]     rx_rem_reg, rx_rem_next;
    logic [LEN_BITS-1:0]     rx_total_reg, rx_total_next;
    logic [6:0]              target_addr_reg, target_addr_next;
    logic                    hold_bus_reg, hold_bus_next;
    logic                    ev_en_reg, ev_en_next;
    logic                    buf_en_reg, buf_en_next;
    logic                    err_en_reg, err_en_next;
    logic                    ack_state_reg, ack_next;
    logic                    ack_enable_reg;

    logic [LEN_BITS-1:0] len_in;
    logic [i2cmis_pkg::STATUS_W-1:0] st;
    logic is_start, is_event, is_error, start_ok;
    logic ev, bufen, sb_hit, addr_hit, btf_close, stopf_hit;
    logic tx_write, rx_read, rx_take, rx_close, ack_drop, closing;

    assign cfg_ready = 1'b1;
    assign len_in    = LEN_BITS'(item.length);
    assign st        = item.status;

    // flag decode shared by next-state and result logic
    always_comb begin
        is_start  = (item.cmd == i2cmis_pkg::CMD_START_TX) ||
                    (item.cmd == i2cmis_pkg::CMD_START_RX);
        is_event  = item.cmd == i2cmis_pkg::CMD_EVENT;
        is_error  = item.cmd == i2cmis_pkg::CMD_ERROR;
        start_ok  = is_start && (xfer_state_reg == i2cmis_pkg::ST_READY);
        ev        = is_event && ev_en_reg;
        bufen     = ev && buf_en_reg;
        sb_hit    = ev && st[i2cmis_pkg::SB_BIT];
        addr_hit  = ev && st[i2cmis_pkg::ADDR_BIT];
        stopf_hit = ev && st[i2cmis_pkg::STOPF_BIT];
        btf_close = ev && st[i2cmis_pkg::BTF_BIT] && st[i2cmis_pkg::TXE_BIT] &&
                    (xfer_state_reg == i2cmis_pkg::ST_BUSY_TX) && (tx_rem_reg == '0);
        tx_write  = bufen && st[i2cmis_pkg::TXE_BIT] && item.master_mode &&
                    (xfer_state_reg == i2cmis_pkg::ST_BUSY_TX) && (tx_rem_reg != '0);
        rx_read   = bufen && st[i2cmis_pkg::RXNE_BIT] && item.master_mode &&
                    (xfer_state_reg == i2cmis_pkg::ST_BUSY_RX);
        rx_take   = rx_read && (rx_total_reg != '0);
        rx_close  = rx_read && (rx_take ? ((rx_rem_reg >> 1) == '0) : (rx_rem_reg == '0));
        ack_drop  = (addr_hit && item.master_mode &&
                     (xfer_state_reg == i2cmis_pkg::ST_BUSY_RX) &&
                     (rx_total_reg == LEN_BITS'(1))) ||
                    (rx_take && (rx_total_reg > LEN_BITS'(1)) &&
                     (rx_rem_reg == LEN_BITS'(2)));
        closing   = btf_close || rx_close;
    end

    // next state
    always_comb begin
        xfer_state_next  = xfer_state_reg;
        tx_rem_next      = tx_rem_reg;
        rx_rem_next      = rx_rem_reg;
        rx_total_next    = rx_total_reg;
        target_addr_next = target_addr_reg;
        hold_bus_next    = hold_bus_reg;
        ev_en_next       = ev_en_reg;
        buf_en_next      = buf_en_reg;
        err_en_next      = err_en_reg;
        if (start_ok) begin
            if (item.cmd == i2cmis_pkg::CMD_START_TX) begin
                xfer_state_next = i2cmis_pkg::ST_BUSY_TX;
                tx_rem_next     = len_in;
            end else begin
                xfer_state_next = i2cmis_pkg::ST_BUSY_RX;
                rx_rem_next     = len_in;
                rx_total_next   = len_in;
            end
            target_addr_next = item.slave_addr;
            hold_bus_next    = item.repeat_start;
            ev_en_next       = 1'b1;
            buf_en_next      = 1'b1;
            err_en_next      = 1'b1;
        end
        if (tx_write) begin
            tx_rem_next = tx_rem_reg - LEN_BITS'(1);
        end
        if (rx_take) begin
            rx_rem_next = rx_rem_reg - LEN_BITS'(1);
        end
        if (rx_close) begin
            rx_rem_next   = '0;
            rx_total_next = '0;
        end
        if (closing) begin
            xfer_state_next = i2cmis_pkg::ST_READY;
            ev_en_next      = 1'b0;
            buf_en_next     = 1'b0;
        end
        if (rx_close && ack_enable_reg) begin
            ack_next = 1'b1;
        end else if (ack_drop) begin
            ack_next = 1'b0;
        end else begin
            ack_next = ack_state_reg;
        end
    end

    // result fields
    always_comb begin
        res             = '0;
        res.prior_state = xfer_state_reg;
        res.start_gen   = start_ok;
        res.stop_gen    = closing && !hold_bus_reg;
        if (tx_write) begin
            res.dr_write = 1'b1;
            res.dr_value = item.tx_byte;
        end else if (sb_hit && (xfer_state_reg == i2cmis_pkg::ST_BUSY_TX)) begin
            res.dr_write = 1'b1;
            res.dr_value = {target_addr_reg, 1'b0};
        end else if (sb_hit && (xfer_state_reg == i2cmis_pkg::ST_BUSY_RX)) begin
            res.dr_write = 1'b1;
            res.dr_value = {target_addr_reg, 1'b1};
        end
        res.tx_advance = tx_write;
        res.rx_store   = rx_take;
        res.rx_value   = rx_take ? item.rx_byte : 8'd0;
        res.addr_clear = addr_hit;
        res.ack_bit    = ack_next;
        res.event_mask = {stopf_hit, rx_close, btf_close};
        if (is_error && err_en_reg) begin
            res.error_mask = {st[i2cmis_pkg::TIMEOUT_BIT], st[i2cmis_pkg::OVR_BIT],
                              st[i2cmis_pkg::AF_BIT], st[i2cmis_pkg::ARLO_BIT],
                              st[i2cmis_pkg::BERR_BIT]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xfer_state_reg  <= i2cmis_pkg::ST_READY;
            tx_rem_reg      <= '0;
            rx_rem_reg      <= '0;
            rx_total_reg    <= '0;
            target_addr_reg <= '0;
            hold_bus_reg    <= 1'b0;
            ev_en_reg       <= 1'b0;
            buf_en_reg      <= 1'b0;
            err_en_reg      <= 1'b0;
        end else if (adv) begin
            xfer_state_reg  <= xfer_state_next;
            tx_rem_reg      <= tx_rem_next;
            rx_rem_reg      <= rx_rem_next;
            rx_total_reg    <= rx_total_next;
            target_addr_reg <= target_addr_next;
            hold_bus_reg    <= hold_bus_next;
            ev_en_reg       <= ev_en_next;
            buf_en_reg      <= buf_en_next;
            err_en_reg      <= err_en_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_enable_reg <= 1'b1;
            ack_state_reg  <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            ack_enable_reg <= cfg_data;
            ack_state_reg  <= cfg_data;
        end else if (adv) begin
            ack_state_reg  <= ack_next;
        end
    end

    a_start_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && start_ok |=> xfer_state_reg != i2cmis_pkg::ST_READY)
        else $error("start transfer did not leave ready state");

    a_ready_irq_off: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer_state_reg == i2cmis_pkg::ST_READY |-> !ev_en_reg && !buf_en_reg)
        else $error("interrupts enabled while ready");

    a_stop_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        res.stop_gen |-> res.event_mask[0] || res.event_mask[1])
        else $error("stop requested without a completion");

    a_rx_zero_at_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && rx_close |=> rx_rem_reg == '0 && rx_total_reg == '0)
        else $error("receive counters not cleared on close");

    a_one_action_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        res.tx_advance |-> res.dr_write && !res.rx_store)
        else $error("transmit advance without data write");

endmodule

// ----- rtl/i2cmis_out_stage.sv -----
// Result register: holds one result transfer until the master side takes it.
module i2cmis_out_stage (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  i2cmis_pkg::result_t                   res,
    output logic                                  out_ready,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [i2cmis_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic                m_valid_reg;
    logic                m_valid_next;
    i2cmis_pkg::result_t res_reg;

    assign out_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res;
        end
    end

    assign m_tdata = {7'd0,
                      res_reg.error_mask,
                      res_reg.event_mask,
                      res_reg.ack_bit,
                      res_reg.addr_clear,
                      res_reg.rx_value,
                      res_reg.rx_store,
                      res_reg.tx_advance,
                      res_reg.dr_value,
                      res_reg.dr_write,
                      res_reg.stop_gen,
                      res_reg.start_gen,
                      res_reg.prior_state};

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for i2c_master_interrupt_sequencer: directed table plus random transfers.
`timescale 1ns / 1ps

module tb_top;
    import i2cmis_pkg::*;

    localparam logic [15:0] SB_F    = 16'h1 << SB_BIT;
    localparam logic [15:0] ADDR_F  = 16'h1 << ADDR_BIT;
    localparam logic [15:0] BTF_F   = 16'h1 << BTF_BIT;
    localparam logic [15:0] STOPF_F = 16'h1 << STOPF_BIT;
    localparam logic [15:0] RXNE_F  = 16'h1 << RXNE_BIT;
    localparam logic [15:0] TXE_F   = 16'h1 << TXE_BIT;
    localparam int PHASE_ITEMS    = 350;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t res;
    } row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = 1'b0;

    // predictor state
    xfer_state_t          pr_state;
    logic [LENGTH_W-1:0]  pr_tx_left, pr_rx_left, pr_rx_total;
    logic [6:0]           pr_addr;
    logic                 pr_hold, pr_ev_en, pr_buf_en, pr_err_en, pr_ack, pr_ack_default;

    row_t    pending_q[$];
    result_t bus_action_q[$];
    row_t    directed_q[$];
    int      mismatch_count = 0;
    int      sent_count     = 0;
    int      sender_idle_pct = 0;
    int      recv_stall_pct  = 0;
    int      hold_requests   = 0;
    int      hold_served     = 0;
    int      hold_left       = 0;
    int      quiet_cycles    = 0;

    i2c_master_interrupt_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic item_t mk_item(cmd_t cmd, logic [15:0] len, logic [6:0] addr,
                                      logic rs, logic [15:0] status, logic master,
                                      logic [7:0] txb, logic [7:0] rxb);
        item_t it;
        it.cmd          = cmd;
        it.length       = len;
        it.slave_addr   = addr;
        it.repeat_start = rs;
        it.status       = status;
        it.master_mode  = master;
        it.tx_byte      = txb;
        it.rx_byte      = rxb;
        return it;
    endfunction

    function automatic item_t rand_item(cmd_t cmd);
        return mk_item(cmd, 16'($urandom), 7'($urandom), 1'($urandom), 16'($urandom),
                       1'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic result_t mk_result(xfer_state_t prior, logic start, logic drw,
                                          logic [7:0] drv, logic ack, logic [4:0] erm);
        result_t r;
        r             = '0;
        r.prior_state = prior;
        r.start_gen   = start;
        r.dr_write    = drw;
        r.dr_value    = drv;
        r.ack_bit     = ack;
        r.error_mask  = erm;
        return r;
    endfunction

    function automatic result_t unpack_result(logic [M_TDATA_W-1:0] d);
        result_t r;
        r.prior_state = d[1:0];
        r.start_gen   = d[2];
        r.stop_gen    = d[3];
        r.dr_write    = d[4];
        r.dr_value    = d[12:5];
        r.tx_advance  = d[13];
        r.rx_store    = d[14];
        r.rx_value    = d[22:15];
        r.addr_clear  = d[23];
        r.ack_bit     = d[24];
        r.event_mask  = d[27:25];
        r.error_mask  = d[32:28];
        return r;
    endfunction

    function automatic string fmt_result(result_t r);
        return $sformatf({"prior=%0d start=%0d stop=%0d drw=%0d drv=%02h txa=%0d rxs=%0d ",
                          "rxv=%02h aclr=%0d ack=%0d evm=%0d erm=%02h"},
                         r.prior_state, r.start_gen, r.stop_gen, r.dr_write, r.dr_value,
                         r.tx_advance, r.rx_store, r.rx_value, r.addr_clear, r.ack_bit,
                         r.event_mask, r.error_mask);
    endfunction

    task automatic reset_predictor();
        pr_state       = ST_READY;
        pr_tx_left     = '0;
        pr_rx_left     = '0;
        pr_rx_total    = '0;
        pr_addr        = '0;
        pr_hold        = 1'b0;
        pr_ev_en       = 1'b0;
        pr_buf_en      = 1'b0;
        pr_err_en      = 1'b0;
        pr_ack         = 1'b1;
        pr_ack_default = 1'b1;
    endtask

    function automatic result_t predict_bus_actions(item_t it);
        result_t r;
        logic    ev, buf_on;
        r             = '0;
        r.prior_state = pr_state;
        ev            = pr_ev_en;
        buf_on        = pr_buf_en;
        case (it.cmd)
            CMD_START_TX, CMD_START_RX: begin
                if (pr_state == ST_READY) begin
                    if (it.cmd == CMD_START_TX) begin
                        pr_tx_left = it.length;
                        pr_state   = ST_BUSY_TX;
                    end else begin
                        pr_rx_left  = it.length;
                        pr_rx_total = it.length;
                        pr_state    = ST_BUSY_RX;
                    end
                    pr_addr     = it.slave_addr;
                    pr_hold     = it.repeat_start;
                    r.start_gen = 1'b1;
                    pr_ev_en    = 1'b1;
                    pr_buf_en   = 1'b1;
                    pr_err_en   = 1'b1;
                end
            end
            CMD_EVENT: begin
                if (ev && it.status[SB_BIT]) begin
                    if (pr_state == ST_BUSY_TX) begin
                        r.dr_write = 1'b1;
                        r.dr_value = {pr_addr, 1'b0};
                    end else if (pr_state == ST_BUSY_RX) begin
                        r.dr_write = 1'b1;
                        r.dr_value = {pr_addr, 1'b1};
                    end
                end
                if (ev && it.status[ADDR_BIT]) begin
                    if (it.master_mode && pr_state == ST_BUSY_RX && pr_rx_total == 1)
                        pr_ack = 1'b0;
                    r.addr_clear = 1'b1;
                end
                if (ev && it.status[BTF_BIT] && pr_state == ST_BUSY_TX && it.status[TXE_BIT]
                        && pr_tx_left == 0) begin
                    r.stop_gen      = !pr_hold;
                    pr_ev_en        = 1'b0;
                    pr_buf_en       = 1'b0;
                    pr_state        = ST_READY;
                    r.event_mask[0] = 1'b1;
                end
                if (ev && it.status[STOPF_BIT])
                    r.event_mask[2] = 1'b1;
                if (ev && buf_on && it.status[TXE_BIT] && it.master_mode
                        && pr_state == ST_BUSY_TX && pr_tx_left != 0) begin
                    r.dr_write   = 1'b1;
                    r.dr_value   = it.tx_byte;
                    pr_tx_left   = pr_tx_left - 1;
                    r.tx_advance = 1'b1;
                end
                if (ev && buf_on && it.status[RXNE_BIT] && it.master_mode
                        && pr_state == ST_BUSY_RX) begin
                    if (pr_rx_total != 0) begin
                        if (pr_rx_total > 1 && pr_rx_left == 2)
                            pr_ack = 1'b0;
                        r.rx_store = 1'b1;
                        r.rx_value = it.rx_byte;
                        if (pr_rx_left != 0)
                            pr_rx_left = pr_rx_left - 1;
                    end
                    if (pr_rx_left == 0) begin
                        r.stop_gen      = !pr_hold;
                        pr_ev_en        = 1'b0;
                        pr_buf_en       = 1'b0;
                        pr_state        = ST_READY;
                        pr_rx_total     = '0;
                        if (pr_ack_default)
                            pr_ack = 1'b1;
                        r.event_mask[1] = 1'b1;
                    end
                end
            end
            default: begin
                if (pr_err_en)
                    r.error_mask = {it.status[TIMEOUT_BIT], it.status[OVR_BIT],
                                    it.status[AF_BIT], it.status[ARLO_BIT], it.status[BERR_BIT]};
            end
        endcase
        r.ack_bit = pr_ack;
        return r;
    endfunction

    // transfer monitor: prediction, checking and watchdog
    always @(posedge aclk) begin
        row_t    row;
        result_t got, want;
        bit      moved;
        if (!aresetn) begin
            reset_predictor();
        end else begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                pr_ack_default = cfg_data;
                pr_ack         = cfg_data;
                moved          = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got = unpack_result(m_tdata);
                if (bus_action_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: %s", fmt_result(got));
                    mismatch_count++;
                end else begin
                    want = bus_action_q.pop_front();
                    if (got.prior_state !== want.prior_state || got.start_gen !== want.start_gen
                        || got.stop_gen !== want.stop_gen || got.dr_write !== want.dr_write
                        || got.dr_value !== want.dr_value || got.tx_advance !== want.tx_advance
                        || got.rx_store !== want.rx_store || got.rx_value !== want.rx_value
                        || got.addr_clear !== want.addr_clear || got.ack_bit !== want.ack_bit
                        || got.event_mask !== want.event_mask
                        || got.error_mask !== want.error_mask) begin
                        if (mismatch_count < 10)
                            $display("mismatch at %0t\n  exp %s\n  got %s", $realtime,
                                     fmt_result(want), fmt_result(got));
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                row  = pending_q.pop_front();
                want = predict_bus_actions(row.it);
                bus_action_q.push_back(row.typed ? row.res : want);
            end
            if (moved)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // result side: random stalls plus requested long hold-offs
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready    <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_row(row_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pending_q.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, r.it.rx_byte, r.it.tx_byte, r.it.master_mode, r.it.status,
                     r.it.repeat_start, r.it.slave_addr, r.it.length};
        s_tuser  <= r.it.cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_count++;
    endtask

    task automatic send_item(item_t it);
        row_t r;
        r       = '0;
        r.it    = it;
        send_row(r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0 || bus_action_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_ack_enable(logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] status_noise();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return '0;
        if (r < 95)
            return 16'($urandom) & 16'hFF28;
        return 16'($urandom);
    endfunction

    task automatic send_noise();
        item_t it;
        int    r;
        r = $urandom_range(99);
        if (r < 40) begin
            it = rand_item(CMD_ERROR);
        end else if (r < 80) begin
            it = rand_item(CMD_EVENT);
        end else begin
            it        = rand_item(r < 90 ? CMD_START_TX : CMD_START_RX);
            it.length = 16'($urandom_range(6));
        end
        send_item(it);
    endtask

    // one well-formed transfer with random content, sometimes broken off early
    task automatic run_transfer();
        item_t it;
        bit    is_rx;
        int    len, n, r;
        is_rx = $urandom_range(1);
        r     = $urandom_range(99);
        len   = r < 60 ? $urandom_range(4) : (r < 95 ? $urandom_range(5, 24)
                                                    : $urandom_range(25, 80));
        it        = rand_item(is_rx ? CMD_START_RX : CMD_START_TX);
        it.length = 16'(len);
        send_item(it);
        it        = rand_item(CMD_EVENT);
        it.status = SB_F | status_noise();
        if (!is_rx && $urandom_range(3) == 0)
            it.status |= TXE_F;
        send_item(it);
        it             = rand_item(CMD_EVENT);
        it.status      = ADDR_F | status_noise();
        it.master_mode = ($urandom_range(19) != 0);
        send_item(it);
        n = (is_rx && len == 0) ? 1 : len;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 4)
                send_noise();
            if ($urandom_range(99) < 2)
                return;
            it             = rand_item(CMD_EVENT);
            it.status      = (is_rx ? RXNE_F : TXE_F) | status_noise();
            it.master_mode = ($urandom_range(19) != 0);
            send_item(it);
        end
        if (!is_rx) begin
            it             = rand_item(CMD_EVENT);
            it.status      = BTF_F | TXE_F | status_noise();
            it.master_mode = 1'b1;
            send_item(it);
        end
        if ($urandom_range(99) < 15)
            send_noise();
    endtask

    task automatic add_row(item_t it, logic typed, result_t res);
        row_t r;
        r.it    = it;
        r.typed = typed;
        r.res   = res;
        directed_q.push_back(r);
    endtask

    initial begin
        int phase_start;
        bit extra_done;
        int idle_pct[4]  = '{0, 82, 0, 25};
        int stall_pct[4] = '{0, 0, 82, 25};

        // idle block, interrupts still off
        add_row(mk_item(CMD_ERROR, 0, 0, 0, 16'hFFFF, 1, 0, 0), 1,
                mk_result(ST_READY, 0, 0, 0, 1, 0));
        add_row(mk_item(CMD_EVENT, 0, 0, 0, 16'hFFFF, 1, 8'hFF, 8'hFF), 1,
                mk_result(ST_READY, 0, 0, 0, 1, 0));
        // zero-length receive
        add_row(mk_item(CMD_START_RX, 0, 7'h7F, 0, 0, 0, 0, 0), 1,
                mk_result(ST_READY, 1, 0, 0, 1, 0));
        add_row(mk_item(CMD_START_TX, 16'hFFFF, 0, 1, 0, 1, 0, 0), 1,
                mk_result(ST_BUSY_RX, 0, 0, 0, 1, 0));
        add_row(mk_item(CMD_ERROR, 0, 0, 0, 16'hFFFF, 0, 0, 0), 1,
                mk_result(ST_BUSY_RX, 0, 0, 0, 1, 5'h1F));
        add_row(mk_item(CMD_ERROR, 0, 0, 0, 16'h4000, 0, 0, 0), 1,
                mk_result(ST_BUSY_RX, 0, 0, 0, 1, 5'h10));
        add_row(mk_item(CMD_EVENT, 0, 0, 0, SB_F, 0, 0, 0), 1,
                mk_result(ST_BUSY_RX, 0, 1, 8'hFF, 1, 0));
        add_row(mk_item(CMD_EVENT, 0, 0, 0, ADDR_F, 1, 0, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, RXNE_F, 1, 0, 8'hFF), 0, '0);
        // two-byte transmit, repeated start
        add_row(mk_item(CMD_START_TX, 2, 0, 1, 0, 1, 0, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, SB_F | TXE_F, 1, 8'hA5, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, STOPF_F | ADDR_F, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, TXE_F, 0, 8'h11, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, BTF_F | TXE_F, 1, 8'hFF, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, BTF_F, 1, 0, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, BTF_F | TXE_F, 1, 0, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, TXE_F, 1, 8'h22, 0), 0, '0);
        // one-byte receive
        add_row(mk_item(CMD_START_RX, 1, 7'h55, 0, 0, 1, 0, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, ADDR_F, 1, 0, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, RXNE_F, 1, 0, 8'hFF), 0, '0);
        // three-byte receive, NACK at two left
        add_row(mk_item(CMD_START_RX, 3, 7'h2A, 1, 0, 1, 0, 0), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, RXNE_F, 1, 0, 8'h00), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, RXNE_F, 1, 0, 8'h81), 0, '0);
        add_row(mk_item(CMD_EVENT, 0, 0, 0, RXNE_F, 1, 0, 8'h7E), 0, '0);

        do @(posedge aclk); while (!aresetn);
        foreach (directed_q[i])
            send_row(directed_q[i]);

        for (int phase = 0; phase < 4; phase++) begin
            if (phase != 0) begin
                drain_results();
                write_ack_enable(phase == 2);
            end
            sender_idle_pct = idle_pct[phase];
            recv_stall_pct  = stall_pct[phase];
            phase_start     = sent_count;
            extra_done      = 0;
            while (sent_count - phase_start < PHASE_ITEMS) begin
                if (!extra_done && phase == 0 && sent_count - phase_start >= 100) begin
                    hold_requests++;
                    extra_done = 1;
                end
                if (!extra_done && phase == 1 && sent_count - phase_start >= 150) begin
                    drain_results();
                    extra_done = 1;
                end
                run_transfer();
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && bus_action_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
